// ----- src/sti_pkg.sv -----
`timescale 1ns / 1ps

package sti_pkg;

  localparam int CAPACITY = 64;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = 64;
  localparam int MW = 7;
  localparam int NW = (CW > MW) ? CW : MW;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KEY_STAMP = 2'd0,
    KEY_UPPER = 2'd1,
    KEY_LOWER = 2'd2
  } key_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SHIFT,
    ST_INS_WR,
    ST_UP_RD,
    ST_UP_CMP,
    ST_LO_RD,
    ST_LO_CMP,
    ST_Q_CHK,
    ST_Q_RD,
    ST_Q_OUT,
    ST_RSP_OK,
    ST_RSP_FULL,
    ST_RSP_NONE
  } state_t;

  typedef struct packed {
    logic [1:0]           command;
    logic signed [DW-1:0] stamp;
    logic [DW-1:0]        payload;
    logic signed [DW-1:0] lower_bound;
    logic signed [DW-1:0] upper_bound;
    logic [MW-1:0]        max_count;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 entry_valid;
    logic signed [DW-1:0] out_stamp;
    logic [DW-1:0]        out_payload;
    logic                 is_last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_item;
    logic     clear_fill;
    logic     srch_init;
    key_sel_t key_sel;
    logic     srch_rd;
    logic     srch_cmp;
    logic     cmp_ge;
    logic     idx_from_lo;
    logic     idx_zero;
    logic     end_from_fill;
    logic     end_from_lo;
    logic     sh_init;
    logic     sh_step;
    logic     ins_write;
    logic     q_rd;
    logic     q_emit;
    logic     rsp_emit;
    status_t  rsp_status;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] command;
    logic       full;
    logic       srch_go;
    logic       need_shift;
    logic       sh_more;
    logic       upper_pos;
    logic       lower_pos;
    logic       q_empty;
    logic       q_last;
    logic       out_free;
  } sts_t;

endpackage

// ----- src/sti_ram.sv -----
`timescale 1ns / 1ps

module sti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/sti_dp.sv -----
`timescale 1ns / 1ps

module sti_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  sti_pkg::in_t  in_data,
  input  sti_pkg::ctl_t ctl,
  output sti_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_stall,
  output sti_pkg::out_t out_data
);

  import sti_pkg::*;

  in_t                  item_r, item_nxt;
  logic signed [DW-1:0] key_r, key_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        end_r, end_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;

  logic [CW-1:0]        mid;
  logic [CW-1:0]        idx_dec;
  logic [CW-1:0]        idx_inc;
  logic [CW-1:0]        n_inc;
  logic signed [DW-1:0] rd_stamp;
  logic [DW-1:0]        rd_payload;
  logic                 cmp_hit;
  logic                 out_free;
  logic                 q_last;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [2*DW-1:0]      ram_wdata;
  logic                 ram_re;
  logic [CW-1:0]        ram_raddr_full;
  logic [2*DW-1:0]      ram_rdata;

  // Each entry holds the stamp in the upper half and the payload in the lower.
  sti_ram #(
    .WIDTH (2 * DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign mid        = lo_r + ((hi_r - lo_r) >> 1);
  assign idx_dec    = idx_r - CW'(1);
  assign idx_inc    = idx_r + CW'(1);
  assign n_inc      = n_r + CW'(1);
  assign rd_stamp   = ram_rdata[2*DW-1:DW];
  assign rd_payload = ram_rdata[DW-1:0];
  assign cmp_hit    = ctl.cmp_ge ? (rd_stamp >= key_r) : (rd_stamp > key_r);
  assign out_free   = !out_valid_r || !out_stall;
  assign q_last     = (idx_inc >= end_r) ||
                      ((item_r.max_count != '0) && (NW'(n_inc) >= NW'(item_r.max_count)));

  always_comb begin
    ram_we    = ctl.sh_step || ctl.ins_write;
    ram_waddr = ctl.ins_write ? lo_r[AW-1:0] : idx_r[AW-1:0];
    ram_wdata = ctl.ins_write ? {item_r.stamp, item_r.payload} : ram_rdata;
    ram_re    = ctl.srch_rd || ctl.sh_init || (ctl.sh_step && sts.sh_more) || ctl.q_rd;
    priority if (ctl.srch_rd) begin
      ram_raddr_full = mid;
    end else if (ctl.sh_init) begin
      ram_raddr_full = fill_r - CW'(1);
    end else if (ctl.sh_step) begin
      ram_raddr_full = idx_r - CW'(2);
    end else begin
      ram_raddr_full = idx_r;
    end
  end

  always_comb begin
    item_nxt      = item_r;
    key_nxt       = key_r;
    fill_nxt      = fill_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (ctl.load_item) begin
      item_nxt = in_data;
      n_nxt    = '0;
    end
    if (ctl.clear_fill) begin
      fill_nxt = '0;
    end
    if (ctl.srch_init) begin
      lo_nxt = '0;
      hi_nxt = fill_r;
      unique case (ctl.key_sel)
        KEY_STAMP: key_nxt = item_r.stamp;
        KEY_UPPER: key_nxt = item_r.upper_bound;
        KEY_LOWER: key_nxt = item_r.lower_bound;
        default:   key_nxt = item_r.stamp;
      endcase
    end
    if (ctl.srch_cmp) begin
      if (cmp_hit) begin
        lo_nxt = mid + CW'(1);
      end else begin
        hi_nxt = mid;
      end
    end
    if (ctl.idx_from_lo) begin
      idx_nxt = lo_r;
    end
    if (ctl.idx_zero) begin
      idx_nxt = '0;
    end
    if (ctl.end_from_fill) begin
      end_nxt = fill_r;
    end
    if (ctl.end_from_lo) begin
      end_nxt = lo_r;
    end
    if (ctl.sh_init) begin
      idx_nxt = fill_r;
    end
    if (ctl.sh_step && sts.sh_more) begin
      idx_nxt = idx_dec;
    end
    if (ctl.ins_write) begin
      fill_nxt = fill_r + CW'(1);
    end
    if (ctl.q_emit) begin
      idx_nxt                  = idx_inc;
      n_nxt                    = n_inc;
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = STS_OK;
      out_data_nxt.entry_valid = 1'b1;
      out_data_nxt.out_stamp   = rd_stamp;
      out_data_nxt.out_payload = rd_payload;
      out_data_nxt.is_last     = q_last;
    end
    if (ctl.rsp_emit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = ctl.rsp_status;
      out_data_nxt.entry_valid = 1'b0;
      out_data_nxt.out_stamp   = '0;
      out_data_nxt.out_payload = '0;
      out_data_nxt.is_last     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    idx_r      <= idx_nxt;
    end_r      <= end_nxt;
    n_r        <= n_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    sts.command    = item_r.command;
    sts.full       = fill_r >= CW'(CAPACITY);
    sts.srch_go    = lo_r < hi_r;
    sts.need_shift = fill_r > lo_r;
    sts.sh_more    = idx_dec > lo_r;
    sts.upper_pos  = item_r.upper_bound > 64'sd0;
    sts.lower_pos  = item_r.lower_bound > 64'sd0;
    sts.q_empty    = idx_r >= end_r;
    sts.q_last     = q_last;
    sts.out_free   = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/sti_ctrl.sv -----
`timescale 1ns / 1ps

module sti_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sti_pkg::sts_t sts,
  output sti_pkg::ctl_t ctl
);

  import sti_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (sts.command)
          CMD_CLEAR:  state_nxt = ST_RSP_OK;
          CMD_INSERT: state_nxt = sts.full ? ST_RSP_FULL : ST_INS_RD;
          CMD_QUERY: begin
            priority if (sts.upper_pos) state_nxt = ST_UP_RD;
            else if (sts.lower_pos)     state_nxt = ST_LO_RD;
            else                        state_nxt = ST_Q_CHK;
          end
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_INS_RD: begin
        priority if (sts.srch_go)  state_nxt = ST_INS_CMP;
        else if (sts.need_shift)   state_nxt = ST_SHIFT;
        else                       state_nxt = ST_INS_WR;
      end
      ST_INS_CMP: state_nxt = ST_INS_RD;
      ST_SHIFT: begin
        if (!sts.sh_more) state_nxt = ST_INS_WR;
      end
      ST_INS_WR: state_nxt = ST_RSP_OK;
      ST_UP_RD: begin
        priority if (sts.srch_go) state_nxt = ST_UP_CMP;
        else if (sts.lower_pos)   state_nxt = ST_LO_RD;
        else                      state_nxt = ST_Q_CHK;
      end
      ST_UP_CMP: state_nxt = ST_UP_RD;
      ST_LO_RD: begin
        state_nxt = sts.srch_go ? ST_LO_CMP : ST_Q_CHK;
      end
      ST_LO_CMP: state_nxt = ST_LO_RD;
      ST_Q_CHK: state_nxt = sts.q_empty ? ST_RSP_NONE : ST_Q_RD;
      ST_Q_RD:  state_nxt = ST_Q_OUT;
      ST_Q_OUT: begin
        if (sts.out_free) state_nxt = sts.q_last ? ST_IDLE : ST_Q_RD;
      end
      ST_RSP_OK, ST_RSP_FULL, ST_RSP_NONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.key_sel    = KEY_STAMP;
    ctl.rsp_status = STS_OK;
    in_stall       = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        ctl.load_item = in_valid;
      end
      ST_DISPATCH: begin
        unique case (sts.command)
          CMD_CLEAR:  ctl.clear_fill = 1'b1;
          CMD_INSERT: ctl.srch_init = !sts.full;
          CMD_QUERY: begin
            priority if (sts.upper_pos) begin
              ctl.srch_init = 1'b1;
              ctl.key_sel   = KEY_UPPER;
            end else if (sts.lower_pos) begin
              ctl.srch_init = 1'b1;
              ctl.key_sel   = KEY_LOWER;
              ctl.idx_zero  = 1'b1;
            end else begin
              ctl.idx_zero      = 1'b1;
              ctl.end_from_fill = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_INS_RD: begin
        // Once the search settles, the shift starts by fetching the last entry.
        priority if (sts.srch_go) ctl.srch_rd = 1'b1;
        else if (sts.need_shift)  ctl.sh_init = 1'b1;
        else ;
      end
      ST_INS_CMP: ctl.srch_cmp = 1'b1;
      ST_SHIFT:   ctl.sh_step = 1'b1;
      ST_INS_WR:  ctl.ins_write = 1'b1;
      ST_UP_RD: begin
        if (sts.srch_go) begin
          ctl.srch_rd = 1'b1;
        end else begin
          ctl.idx_from_lo = 1'b1;
          if (sts.lower_pos) begin
            ctl.srch_init = 1'b1;
            ctl.key_sel   = KEY_LOWER;
          end else begin
            ctl.end_from_fill = 1'b1;
          end
        end
      end
      ST_UP_CMP: ctl.srch_cmp = 1'b1;
      ST_LO_RD: begin
        if (sts.srch_go) ctl.srch_rd = 1'b1;
        else             ctl.end_from_lo = 1'b1;
      end
      ST_LO_CMP: begin
        ctl.srch_cmp = 1'b1;
        ctl.cmp_ge   = 1'b1;
      end
      ST_Q_CHK: ;
      ST_Q_RD:  ctl.q_rd = 1'b1;
      ST_Q_OUT: ctl.q_emit = sts.out_free;
      ST_RSP_OK: begin
        ctl.rsp_emit   = sts.out_free;
        ctl.rsp_status = STS_OK;
      end
      ST_RSP_FULL: begin
        ctl.rsp_emit   = sts.out_free;
        ctl.rsp_status = STS_FULL;
      end
      ST_RSP_NONE: begin
        ctl.rsp_emit   = sts.out_free;
        ctl.rsp_status = STS_EMPTY;
      end
      default: ;
    endcase
  end

endmodule

// ----- src/sorted_timeline_index.sv -----
// Sorted timeline index: keeps up to CAPACITY (stamp, payload) pairs in a single
// on-chip RAM, ordered newest first, and serves one request at a time. An
// insert runs a binary search, each step a RAM read and then a compare, moves
// the later entries down one per cycle through the RAM's read and write ports,
// then writes the new pair. A query runs up to two such searches for its
// bounds and then delivers its results one at a time, each entry read from the
// RAM before it is registered at the output. A full table rejects an insert
// with status 1; a query that matches nothing returns a single result with
// status 2. The result register lets a new request be taken while the last
// result is still waiting.
`timescale 1ns / 1ps

module sorted_timeline_index (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sti_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sti_pkg::out_t out_data
);

  import sti_pkg::*;

  ctl_t ctl;
  sts_t sts;

  sti_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  sti_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- src/sti_checker.sv -----
`timescale 1ns / 1ps

module sti_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input sti_pkg::out_t out_data
);

  import sti_pkg::*;

  // A request is worked on alone, so the input closes right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a request was accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.entry_valid) |-> (out_data.status == STS_OK))
    else $error("table entry returned with a non-ok status");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != STS_OK)) |->
      (out_data.is_last && !out_data.entry_valid))
    else $error("error result is not a single final result");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.entry_valid) |->
      ((out_data.out_stamp == '0) && (out_data.out_payload == '0) && out_data.is_last))
    else $error("result without an entry carries data");

endmodule

bind sorted_timeline_index sti_checker u_sti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/sti_result_check.sv -----
`timescale 1ns / 1ps

module sti_result_check (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  sti_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  sti_pkg::out_t out_data,
  output int unsigned   errors,
  output int unsigned   waiting
);

  import sti_pkg::*;

  logic signed [DW-1:0] stamp_tab [CAPACITY];
  logic [DW-1:0]        payload_tab [CAPACITY];
  int unsigned          filled;
  out_t                 pending_results [$];

  // The table is kept newest first, so a linear scan finds the same slot as a
  // binary search would.
  function automatic int unsigned first_not_above(logic signed [DW-1:0] key);
    int unsigned i;
    i = 0;
    while (i < filled && stamp_tab[i] > key) i++;
    return i;
  endfunction

  function automatic int unsigned lead_not_below(logic signed [DW-1:0] key);
    int unsigned i;
    i = 0;
    while (i < filled && stamp_tab[i] >= key) i++;
    return i;
  endfunction

  task automatic apply_request(in_t req);
    out_t        r;
    int unsigned pos;
    int unsigned first;
    int unsigned stop;
    int unsigned total;
    int unsigned k;
    r = '0;
    r.is_last = 1'b1;
    case (req.command)
      CMD_CLEAR: begin
        filled = 0;
        pending_results.push_back(r);
      end
      CMD_INSERT: begin
        if (filled >= CAPACITY) begin
          r.status = STS_FULL;
        end else begin
          // A new entry goes ahead of any entries with an equal stamp.
          pos = first_not_above(req.stamp);
          for (k = filled; k > pos; k--) begin
            stamp_tab[k]   = stamp_tab[k-1];
            payload_tab[k] = payload_tab[k-1];
          end
          stamp_tab[pos]   = req.stamp;
          payload_tab[pos] = req.payload;
          filled++;
        end
        pending_results.push_back(r);
      end
      CMD_QUERY: begin
        first = (req.upper_bound > 0) ? first_not_above(req.upper_bound) : 0;
        stop  = (req.lower_bound > 0) ? lead_not_below(req.lower_bound) : filled;
        total = (stop > first) ? stop - first : 0;
        if (req.max_count != 0 && total > req.max_count) total = req.max_count;
        if (total == 0) begin
          r.status = STS_EMPTY;
          pending_results.push_back(r);
        end else begin
          for (k = 0; k < total; k++) begin
            r.status      = STS_OK;
            r.entry_valid = 1'b1;
            r.out_stamp   = stamp_tab[first+k];
            r.out_payload = payload_tab[first+k];
            r.is_last     = (k == total - 1);
            pending_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      filled = 0;
      errors = 0;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: status=%0d valid=%0b stamp=%0d payload=%h last=%0b",
                     out_data.status, out_data.entry_valid, out_data.out_stamp,
                     out_data.out_payload, out_data.is_last);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status || out_data.entry_valid !== want.entry_valid ||
              out_data.out_stamp !== want.out_stamp ||
              out_data.out_payload !== want.out_payload ||
              out_data.is_last !== want.is_last) begin
            if (errors < 10) begin
              $display("mismatch: expected status=%0d valid=%0b stamp=%0d payload=%h last=%0b",
                       want.status, want.entry_valid, want.out_stamp, want.out_payload,
                       want.is_last);
              $display("          got      status=%0d valid=%0b stamp=%0d payload=%h last=%0b",
                       out_data.status, out_data.entry_valid, out_data.out_stamp,
                       out_data.out_payload, out_data.is_last);
            end
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) apply_request(in_data);
    end
    waiting = pending_results.size();
  end

endmodule

// ----- tb/tb_sorted_timeline_index.sv -----
`timescale 1ns / 1ps

module tb_sorted_timeline_index;
  import sti_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 380;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned HOLD_AT      = 120;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CALM_FROM    = 200;
  localparam int unsigned CALM_TO      = 260;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  int unsigned errors;
  int unsigned waiting;
  int unsigned taken       = 0;
  int unsigned cycles      = 0;
  int unsigned table_guess = 0;
  bit          calm        = 1'b0;

  always #2 clk = ~clk;

  sorted_timeline_index u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sti_result_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .errors    (errors),
    .waiting   (waiting)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_sorted_timeline_index: errors");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off so that the block backs up.
  initial begin : receiver
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && taken >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 32);
      end
    end
  end

  task automatic send(in_t req);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    taken++;
    calm = (taken >= CALM_FROM && taken < CALM_TO);
    if (req.command == CMD_CLEAR) table_guess = 0;
    else if (req.command == CMD_INSERT && table_guess < CAPACITY) table_guess++;
  endtask

  function automatic in_t noise();
    in_t r;
    r.command     = 2'($urandom);
    r.stamp       = {$urandom, $urandom};
    r.payload     = {$urandom, $urandom};
    r.lower_bound = {$urandom, $urandom};
    r.upper_bound = {$urandom, $urandom};
    r.max_count   = 7'($urandom_range(0, 64));
    return r;
  endfunction

  // Mostly small stamps, so that duplicates and narrow ranges are common.
  function automatic logic signed [DW-1:0] pick_stamp();
    case ($urandom_range(9))
      0, 1:    return {$urandom, $urandom};
      2:       return 64'(0) - 64'($urandom_range(1, 40));
      default: return 64'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic logic signed [DW-1:0] pick_bound();
    int unsigned k;
    k = $urandom_range(19);
    if (k < 7) return '0;
    if (k == 7) return {1'b1, 31'($urandom), $urandom};
    if (k < 10) return {$urandom, $urandom};
    return 64'($urandom_range(1, 45));
  endfunction

  task automatic do_clear();
    in_t r;
    r = noise();
    r.command = CMD_CLEAR;
    send(r);
  endtask

  task automatic do_insert(logic signed [DW-1:0] st, logic [DW-1:0] pl);
    in_t r;
    r = noise();
    r.command = CMD_INSERT;
    r.stamp   = st;
    r.payload = pl;
    send(r);
  endtask

  task automatic do_query(logic signed [DW-1:0] lo, logic signed [DW-1:0] up,
                          logic [MW-1:0] cap);
    in_t r;
    r = noise();
    r.command     = CMD_QUERY;
    r.lower_bound = lo;
    r.upper_bound = up;
    r.max_count   = cap;
    send(r);
  endtask

  initial begin : stimulus
    in_t         r;
    int unsigned i;
    int unsigned k;
    int unsigned burst;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    do_query('0, '0, '0);
    r = noise();
    r.command = CMD_UNUSED;
    send(r);
    do_insert(64'sh7FFF_FFFF_FFFF_FFFF, '1);
    do_insert(64'sh8000_0000_0000_0000, '0);
    do_insert(0, 64'h5555_5555_5555_5555);
    do_insert(10, 64'hAAAA_AAAA_AAAA_AAAA);
    do_insert(10, 64'h0123_4567_89AB_CDEF);
    do_insert(-5, 64'hFEDC_BA98_7654_3210);
    do_query('0, '0, '0);
    do_query('0, '0, 7'd2);
    do_query('0, '0, 7'd64);
    do_query('0, 10, '0);
    do_query('0, 1, '0);
    do_query(5, '0, '0);
    do_query(11, 9, '0);
    do_query(-3, -1, '0);
    do_query(64'sh7FFF_FFFF_FFFF_FFFF, '0, '0);
    do_query('0, 64'sh7FFF_FFFF_FFFF_FFFF, 7'd1);
    do_clear();
    do_insert(100, 64'h1);
    do_query('0, 50, '0);
    do_query(200, '0, '0);
    do_query(100, 100, '0);

    i = 0;
    while (i < RANDOM_ITEMS) begin
      k = $urandom_range(99);
      if (k < 4) begin
        do_clear();
        i++;
      end else if (k < 6) begin
        // The unused command code is ignored, so it does not count.
        r = noise();
        r.command = CMD_UNUSED;
        send(r);
      end else if (k < 9) begin
        // Fill the table and run a few requests into the full condition.
        burst = CAPACITY - table_guess + $urandom_range(1, 3);
        repeat (burst) do_insert(pick_stamp(), {$urandom, $urandom});
        i += burst;
      end else if (k < 55) begin
        do_insert(pick_stamp(), {$urandom, $urandom});
        i++;
      end else begin
        do_query(pick_bound(), pick_bound(),
                 $urandom_range(1) ? 7'd0 : 7'($urandom_range(1, 64)));
        i++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("tb_sorted_timeline_index: clean");
    end else begin
      $display("tb_sorted_timeline_index: errors");
    end
    $finish;
  end

endmodule
